>>> hdl/bai_pkg.sv
package bai_pkg;

   // Register file layout
   localparam int VERTEX_WIDTH    = 48;
   localparam int LIMIT_WIDTH     = 18;
   localparam int LIMIT_FRAC_BITS = 16;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 18'd65601;  // 1.001 in Q2.16

   // Datapath shape
   localparam int NUM_VERTS = 3;
   localparam int NUM_AXES  = 3;
   localparam int NUM_LANES = 4;  // full triangle, then the three sub-triangles
   localparam int NUM_SUBS  = 3;

   typedef enum logic [1:0] {
      CSR_VERTEX_A     = 2'd0,
      CSR_VERTEX_B     = 2'd1,
      CSR_VERTEX_C     = 2'd2,
      CSR_INSIDE_LIMIT = 2'd3
   } csr_index_type;

endpackage

>>> hdl/barycentric_attribute_interpolator_core.sv
// The path from an accepted request to its response holds one register per root bit
// and one per quotient bit.
// Throughput: one transaction per cycle unless the skid register holds a stalled response.
// Reset (synchronous, active high) empties the pipeline and the output buffer, clears
// the vertices and sets inside_limit to 1.001.
module barycentric_attribute_interpolator_core #(
   parameter int COORD_BITS       = 16,
   parameter int VALUE_BITS       = 16,
   parameter int WEIGHT_FRAC_BITS = 16,
   localparam int CSR_W = (3 * COORD_BITS > bai_pkg::VERTEX_WIDTH) ?
                          3 * COORD_BITS : bai_pkg::VERTEX_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   // configuration
   input  logic                         csr_write_enable,
   input  logic [1:0]                   csr_index,
   input  logic [CSR_W-1:0]             csr_write_data,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   input  logic signed [COORD_BITS-1:0] req_point_z,
   input  logic signed [VALUE_BITS-1:0] req_attr_at_a,
   input  logic signed [VALUE_BITS-1:0] req_attr_at_b,
   input  logic signed [VALUE_BITS-1:0] req_attr_at_c,
   input  logic                         req_last_element,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [VALUE_BITS-1:0] rsp_blended_value,
   output logic                         rsp_inside_res,
   output logic                         rsp_last_out
);

   localparam int CB   = COORD_BITS;
   localparam int W    = WEIGHT_FRAC_BITS;
   localparam int DB   = CB + 1;           // coordinate difference
   localparam int PB   = 2 * DB;           // partial cross product
   localparam int MB   = PB;               // cross component magnitude
   localparam int H    = (MB + 1) / 2;     // low half for squaring
   localparam int HB   = MB - H;           // high half for squaring
   localparam int SQ   = 2 * MB + 2;       // squared length
   localparam int LB   = MB + 1;           // length
   localparam int WB   = W + 2;            // weight, Q2.W
   localparam int RB   = LB + 2;           // divider remainder
   localparam int NDV  = WB;               // divider stages
   localparam int PRB  = VALUE_BITS + WB + 1;
   localparam int ACB  = PRB + 2;
   localparam int CW   = W + 24;
   localparam int ST_DV = 5 + LB + NDV;    // last divider stage
   localparam int NST   = ST_DV + 3;       // final pipeline stage
   localparam longint ROUND = longint'(1) << (W - 1);
   localparam longint VMAX  = (longint'(1) << (VALUE_BITS - 1)) - 1;
   localparam longint VMIN  = -VMAX - 1;

   typedef struct packed {
      logic [2:0][VALUE_BITS-1:0] attr;
      logic                       last;
   } side_type;

   typedef struct packed {
      logic [SQ-1:0] rem;
      logic [LB-1:0] root;
   } sq_type;

   typedef struct packed {
      logic [RB-1:0] rem;
      logic [WB-1:0] q;
   } dv_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  in_tri;
      logic                  last;
   } out_type;

   // one root bit: try setting bit b of the root
   function automatic sq_type sq_step(input sq_type s, input int b);
      logic [SQ-1:0] trial;
      sq_type        r;
      trial = (SQ'(s.root) << (b + 1)) | (SQ'(1) << (2 * b));
      r = s;
      if (s.rem >= trial) begin
         r.rem  = s.rem - trial;
         r.root = s.root | (LB'(1) << b);
      end
      return r;
   endfunction

   // one quotient bit of a restoring division
   function automatic dv_type dv_step(input dv_type s, input logic [LB-1:0] full,
                                      input logic dbl, input logic shl);
      logic [RB-1:0] r;
      logic [RB-1:0] d;
      logic          qb;
      dv_type        o;
      r  = shl ? (s.rem << 1) : s.rem;
      d  = dbl ? (RB'(full) << 1) : RB'(full);
      qb = (r >= d);
      o.rem = qb ? (r - d) : r;
      o.q   = {s.q[WB-2:0], qb};
      return o;
   endfunction

   // ---------------------------------------------------------------- registers
   logic [3*CB-1:0]                      vert_ff [bai_pkg::NUM_VERTS];
   logic [bai_pkg::LIMIT_WIDTH-1:0]      limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bai_pkg::NUM_VERTS; i++) begin
            vert_ff[i] <= '0;
         end
         limit_ff <= bai_pkg::LIMIT_RESET;
      end else if (csr_write_enable) begin
         unique case (bai_pkg::csr_index_type'(csr_index))
            bai_pkg::CSR_VERTEX_A:     vert_ff[0] <= csr_write_data[3*CB-1:0];
            bai_pkg::CSR_VERTEX_B:     vert_ff[1] <= csr_write_data[3*CB-1:0];
            bai_pkg::CSR_VERTEX_C:     vert_ff[2] <= csr_write_data[3*CB-1:0];
            bai_pkg::CSR_INSIDE_LIMIT: limit_ff <= csr_write_data[bai_pkg::LIMIT_WIDTH-1:0];
         endcase
      end
   end

   // ---------------------------------------------------------------- pipeline control
   logic            en;
   logic [NST:1]    vld_ff, vld_in;
   side_type        side_ff [1:NST-1];
   side_type        side_in [1:NST-1];
   logic            skid_vld_ff, skid_vld_in;

   assign en        = !skid_vld_ff;
   assign req_stall = skid_vld_ff;

   always_comb begin
      vld_in     = {vld_ff[NST-1:1], req_valid};
      side_in[1] = '{attr: {req_attr_at_c, req_attr_at_b, req_attr_at_a},
                     last: req_last_element};
      for (int k = 2; k < NST; k++) begin
         side_in[k] = side_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // ---------------------------------------------------------------- stage 1: differences
   logic signed [DB-1:0] pt [bai_pkg::NUM_AXES];
   logic signed [DB-1:0] va [bai_pkg::NUM_AXES];
   logic signed [DB-1:0] vb [bai_pkg::NUM_AXES];
   logic signed [DB-1:0] vc [bai_pkg::NUM_AXES];
   logic signed [DB-1:0] s1_u_ff [bai_pkg::NUM_LANES][bai_pkg::NUM_AXES];
   logic signed [DB-1:0] s1_v_ff [bai_pkg::NUM_LANES][bai_pkg::NUM_AXES];
   logic signed [DB-1:0] s1_u_in [bai_pkg::NUM_LANES][bai_pkg::NUM_AXES];
   logic signed [DB-1:0] s1_v_in [bai_pkg::NUM_LANES][bai_pkg::NUM_AXES];

   always_comb begin
      pt[0] = DB'(req_point_x);
      pt[1] = DB'(req_point_y);
      pt[2] = DB'(req_point_z);
      for (int k = 0; k < bai_pkg::NUM_AXES; k++) begin
         va[k] = DB'($signed(vert_ff[0][k*CB +: CB]));
         vb[k] = DB'($signed(vert_ff[1][k*CB +: CB]));
         vc[k] = DB'($signed(vert_ff[2][k*CB +: CB]));
         // lane 0: edges; lanes 1..3: point against vertex pairs
         s1_u_in[0][k] = vb[k] - va[k];
         s1_v_in[0][k] = vc[k] - va[k];
         s1_u_in[1][k] = pt[k] - vb[k];
         s1_v_in[1][k] = pt[k] - vc[k];
         s1_u_in[2][k] = pt[k] - vc[k];
         s1_v_in[2][k] = pt[k] - va[k];
         s1_u_in[3][k] = pt[k] - vb[k];
         s1_v_in[3][k] = pt[k] - va[k];
      end
   end

   // ---------------------------------------------------------------- stage 2: products
   logic signed [PB-1:0] s2_p_ff [bai_pkg::NUM_LANES][6];
   logic signed [PB-1:0] s2_p_in [bai_pkg::NUM_LANES][6];

   always_comb begin
      for (int l = 0; l < bai_pkg::NUM_LANES; l++) begin
         s2_p_in[l][0] = PB'(s1_u_ff[l][1]) * PB'(s1_v_ff[l][2]);
         s2_p_in[l][1] = PB'(s1_u_ff[l][2]) * PB'(s1_v_ff[l][1]);
         s2_p_in[l][2] = PB'(s1_u_ff[l][2]) * PB'(s1_v_ff[l][0]);
         s2_p_in[l][3] = PB'(s1_u_ff[l][0]) * PB'(s1_v_ff[l][2]);
         s2_p_in[l][4] = PB'(s1_u_ff[l][0]) * PB'(s1_v_ff[l][1]);
         s2_p_in[l][5] = PB'(s1_u_ff[l][1]) * PB'(s1_v_ff[l][0]);
      end
   end

   // ---------------------------------------------------------------- stage 3: cross magnitudes
   logic [MB-1:0] s3_mag_ff [bai_pkg::NUM_LANES][bai_pkg::NUM_AXES];
   logic [MB-1:0] s3_mag_in [bai_pkg::NUM_LANES][bai_pkg::NUM_AXES];

   always_comb begin
      logic signed [PB:0] cd;
      for (int l = 0; l < bai_pkg::NUM_LANES; l++) begin
         for (int c = 0; c < bai_pkg::NUM_AXES; c++) begin
            cd = (PB+1)'(s2_p_ff[l][2*c]) - (PB+1)'(s2_p_ff[l][2*c+1]);
            s3_mag_in[l][c] = cd[PB] ? MB'(-cd) : MB'(cd);
         end
      end
   end

   // ---------------------------------------------------------------- stage 4: split squares
   logic [2*HB-1:0]  s4_hh_ff [bai_pkg::NUM_LANES][bai_pkg::NUM_AXES];
   logic [HB+H-1:0]  s4_hl_ff [bai_pkg::NUM_LANES][bai_pkg::NUM_AXES];
   logic [2*H-1:0]   s4_ll_ff [bai_pkg::NUM_LANES][bai_pkg::NUM_AXES];
   logic [2*HB-1:0]  s4_hh_in [bai_pkg::NUM_LANES][bai_pkg::NUM_AXES];
   logic [HB+H-1:0]  s4_hl_in [bai_pkg::NUM_LANES][bai_pkg::NUM_AXES];
   logic [2*H-1:0]   s4_ll_in [bai_pkg::NUM_LANES][bai_pkg::NUM_AXES];

   always_comb begin
      for (int l = 0; l < bai_pkg::NUM_LANES; l++) begin
         for (int c = 0; c < bai_pkg::NUM_AXES; c++) begin
            s4_hh_in[l][c] = (2*HB)'(s3_mag_ff[l][c][MB-1:H]) *
                             (2*HB)'(s3_mag_ff[l][c][MB-1:H]);
            s4_hl_in[l][c] = (HB+H)'(s3_mag_ff[l][c][MB-1:H]) *
                             (HB+H)'(s3_mag_ff[l][c][H-1:0]);
            s4_ll_in[l][c] = (2*H)'(s3_mag_ff[l][c][H-1:0]) *
                             (2*H)'(s3_mag_ff[l][c][H-1:0]);
         end
      end
   end

   // ---------------------------------------------------------------- stage 5: squared lengths
   logic [SQ-1:0] s5_n_ff [bai_pkg::NUM_LANES];
   logic [SQ-1:0] s5_n_in [bai_pkg::NUM_LANES];

   always_comb begin
      for (int l = 0; l < bai_pkg::NUM_LANES; l++) begin
         s5_n_in[l] = '0;
         for (int c = 0; c < bai_pkg::NUM_AXES; c++) begin
            s5_n_in[l] = s5_n_in[l] + (SQ'(s4_hh_ff[l][c]) << (2 * H))
                                    + (SQ'(s4_hl_ff[l][c]) << (H + 1))
                                    + SQ'(s4_ll_ff[l][c]);
         end
      end
   end

   // ---------------------------------------------------------------- square root, a bit a stage
   sq_type sr_ff [1:LB][bai_pkg::NUM_LANES];
   sq_type sr_in [1:LB][bai_pkg::NUM_LANES];

   always_comb begin
      for (int l = 0; l < bai_pkg::NUM_LANES; l++) begin
         sr_in[1][l] = sq_step('{rem: s5_n_ff[l], root: '0}, LB - 1);
         for (int i = 2; i <= LB; i++) begin
            sr_in[i][l] = sq_step(sr_ff[i-1][l], LB - i);
         end
      end
   end

   // ---------------------------------------------------------------- weight division
   dv_type                    dv_ff      [1:NDV][bai_pkg::NUM_SUBS];
   dv_type                    dv_in      [1:NDV][bai_pkg::NUM_SUBS];
   logic [bai_pkg::NUM_SUBS-1:0] dv_sat_ff [1:NDV];
   logic [bai_pkg::NUM_SUBS-1:0] dv_sat_in [1:NDV];
   logic [LB-1:0]             dv_full_ff [1:NDV];
   logic [LB-1:0]             dv_full_in [1:NDV];

   always_comb begin
      logic [LB-1:0] full0;
      logic [LB-1:0] sub;
      full0         = sr_ff[LB][0].root;
      dv_full_in[1] = full0;
      for (int j = 0; j < bai_pkg::NUM_SUBS; j++) begin
         sub = sr_ff[LB][j+1].root;
         // degenerate triangle or ratio of four or more saturates
         dv_sat_in[1][j] = (full0 == '0) || ({2'b00, sub} >= {full0, 2'b00});
         dv_in[1][j]     = dv_step('{rem: RB'(sub), q: '0}, full0, 1'b1, 1'b0);
      end
      for (int t = 2; t <= NDV; t++) begin
         dv_full_in[t] = dv_full_ff[t-1];
         dv_sat_in[t]  = dv_sat_ff[t-1];
         for (int j = 0; j < bai_pkg::NUM_SUBS; j++) begin
            dv_in[t][j] = dv_step(dv_ff[t-1][j], dv_full_ff[t-1], 1'b0, (t > 2));
         end
      end
   end

   // ---------------------------------------------------------------- blend: products, inside test
   logic signed [PRB-1:0] bl1_prod_ff [bai_pkg::NUM_SUBS];
   logic signed [PRB-1:0] bl1_prod_in [bai_pkg::NUM_SUBS];
   logic                  bl1_inside_ff, bl1_inside_in;

   always_comb begin
      logic [WB-1:0] w;
      logic [WB+1:0] wsum;
      wsum = '0;
      for (int j = 0; j < bai_pkg::NUM_SUBS; j++) begin
         w = dv_sat_ff[NDV][j] ? {WB{1'b1}} : dv_ff[NDV][j].q;
         wsum = wsum + (WB+2)'(w);
         bl1_prod_in[j] = PRB'($signed(side_ff[ST_DV].attr[j])) * PRB'($signed({1'b0, w}));
      end
      bl1_inside_in = (dv_full_ff[NDV] != '0) &&
                      ((CW'(wsum) << bai_pkg::LIMIT_FRAC_BITS) < (CW'(limit_ff) << W));
   end

   // ---------------------------------------------------------------- blend: sum and round
   logic signed [ACB-1:0] bl2_acc_ff, bl2_acc_in;
   logic                  bl2_inside_ff;

   assign bl2_acc_in = ACB'(bl1_prod_ff[0]) + ACB'(bl1_prod_ff[1]) + ACB'(bl1_prod_ff[2])
                     + ACB'(ROUND);

   // ---------------------------------------------------------------- blend: scale and saturate
   out_type res_ff, res_in;

   always_comb begin
      logic signed [ACB-1:0] res;
      res = bl2_acc_ff >>> W;
      if (res > ACB'(VMAX)) begin
         res_in.value = VALUE_BITS'(VMAX);
      end else if (res < ACB'(VMIN)) begin
         res_in.value = VALUE_BITS'(VMIN);
      end else begin
         res_in.value = res[VALUE_BITS-1:0];
      end
      res_in.in_tri = bl2_inside_ff;
      res_in.last   = side_ff[NST-1].last;
   end

   // datapath registers move together with the valid bits
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff       <= side_in;
         s1_u_ff       <= s1_u_in;
         s1_v_ff       <= s1_v_in;
         s2_p_ff       <= s2_p_in;
         s3_mag_ff     <= s3_mag_in;
         s4_hh_ff      <= s4_hh_in;
         s4_hl_ff      <= s4_hl_in;
         s4_ll_ff      <= s4_ll_in;
         s5_n_ff       <= s5_n_in;
         sr_ff         <= sr_in;
         dv_ff         <= dv_in;
         dv_sat_ff     <= dv_sat_in;
         dv_full_ff    <= dv_full_in;
         bl1_prod_ff   <= bl1_prod_in;
         bl1_inside_ff <= bl1_inside_in;
         bl2_acc_ff    <= bl2_acc_in;
         bl2_inside_ff <= bl1_inside_ff;
         res_ff        <= res_in;
      end
   end

   // ---------------------------------------------------------------- output register and skid
   logic    rsp_valid_ff, rsp_valid_in;
   out_type rsp_out_ff, rsp_out_in;
   out_type skid_ff, skid_in;
   logic    take, push;

   always_comb begin
      take         = rsp_valid_ff && !rsp_stall;
      push         = en && vld_ff[NST];
      rsp_valid_in = rsp_valid_ff;
      rsp_out_in   = rsp_out_ff;
      skid_vld_in  = skid_vld_ff;
      skid_in      = skid_ff;
      if (skid_vld_ff) begin
         if (take) begin
            rsp_out_in  = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (!rsp_valid_ff || take) begin
         rsp_valid_in = push;
         rsp_out_in   = res_ff;
      end else if (push) begin
         skid_vld_in = 1'b1;
         skid_in     = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_vld_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         skid_vld_ff  <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_out_ff <= rsp_out_in;
      skid_ff    <= skid_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_blended_value = $signed(rsp_out_ff.value);
   assign rsp_inside_res    = rsp_out_ff.in_tri;
   assign rsp_last_out      = rsp_out_ff.last;

   // ---------------------------------------------------------------- assertions
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_vld_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("skid register filled without a stalled response");

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> rsp_valid_ff)
      else $error("skid register holds a transaction while the output is empty");

   a_pipe_freeze: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[NST] && !en) |=> (vld_ff[NST] && $stable(res_ff)))
      else $error("final pipeline stage changed while frozen");

endmodule

>>> tb/barycentric_attribute_interpolator_checker.sv
`timescale 1ns / 100ps

// Watches both channels, predicts each response from the request and the
// mirrored register file, and compares in order.
module barycentric_attribute_interpolator_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [47:0]         csr_write_data,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic signed [15:0]  req_point_x,
   input  logic signed [15:0]  req_point_y,
   input  logic signed [15:0]  req_point_z,
   input  logic signed [15:0]  req_attr_at_a,
   input  logic signed [15:0]  req_attr_at_b,
   input  logic signed [15:0]  req_attr_at_c,
   input  logic                req_last_element,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic signed [15:0]  rsp_blended_value,
   input  logic                rsp_inside_res,
   input  logic                rsp_last_out,
   output int                  error_count,
   output int                  pending_count,
   output int                  response_count,
   output int                  inside_count
);

   typedef struct packed {
      logic signed [15:0] blended;
      logic               in_tri;
      logic               last;
   } blend_result_type;

   localparam logic [17:0] WEIGHT_MAX = 18'h3ffff;

   logic [47:0]                     vert_a, vert_b, vert_c;
   logic [bai_pkg::LIMIT_WIDTH-1:0] limit_q;
   blend_result_type                expected_blends[$];

   // floor(sqrt(n)), bitwise restoring method
   function automatic longint unsigned isqrt(logic [127:0] n);
      logic [127:0] root, bitv, rem;
      rem  = n;
      root = 0;
      bitv = 128'd1 << 94;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem  = rem - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root[63:0];
   endfunction

   function automatic longint unsigned span_length(longint u[3], longint v[3]);
      longint       cx, cy, cz;
      logic [127:0] sq;
      cx = u[1] * v[2] - u[2] * v[1];
      cy = u[2] * v[0] - u[0] * v[2];
      cz = u[0] * v[1] - u[1] * v[0];
      // squares exceed 64 bits, so widen before multiplying
      sq = 128'(cx) * 128'(cx) + 128'(cy) * 128'(cy) + 128'(cz) * 128'(cz);
      return isqrt(sq);
   endfunction

   function automatic logic [17:0] area_weight(longint unsigned sub, longint unsigned full);
      logic [127:0] q;
      if (full == 0) return WEIGHT_MAX;
      q = (128'(sub) << 16) / 128'(full);
      if (q > 128'(WEIGHT_MAX)) return WEIGHT_MAX;
      return q[17:0];
   endfunction

   function automatic blend_result_type predict_blend(
         logic signed [15:0] px, py, pz, aa, ab, ac, logic lst);
      longint           p[3], a[3], b[3], c[3], e1[3], e2[3], pa[3], pb[3], pc[3];
      longint unsigned  full;
      logic [17:0]      w0, w1, w2;
      longint           wsum, acc, res;
      blend_result_type r;
      p[0] = px; p[1] = py; p[2] = pz;
      for (int k = 0; k < 3; k++) begin
         a[k]  = $signed(vert_a[k*16 +: 16]);
         b[k]  = $signed(vert_b[k*16 +: 16]);
         c[k]  = $signed(vert_c[k*16 +: 16]);
         e1[k] = b[k] - a[k];
         e2[k] = c[k] - a[k];
         pa[k] = p[k] - a[k];
         pb[k] = p[k] - b[k];
         pc[k] = p[k] - c[k];
      end
      full = span_length(e1, e2);
      w0   = area_weight(span_length(pb, pc), full);
      w1   = area_weight(span_length(pc, pa), full);
      w2   = area_weight(span_length(pb, pa), full);
      wsum = longint'(w0) + longint'(w1) + longint'(w2);
      acc  = longint'(aa) * longint'(w0) + longint'(ab) * longint'(w1)
           + longint'(ac) * longint'(w2) + (64'sd1 <<< 15);
      res  = acc >>> 16;
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
      r.blended = res[15:0];
      // both sides carry 16 fraction bits
      r.in_tri  = (full != 0) && (wsum < longint'(limit_q));
      r.last    = lst;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      blend_result_type want;
      if (reset) begin
         vert_a  = '0;
         vert_b  = '0;
         vert_c  = '0;
         limit_q = bai_pkg::LIMIT_RESET;
         expected_blends.delete();
         error_count    = 0;
         response_count = 0;
         inside_count   = 0;
      end else begin
         // requests are predicted with the registers as they stood before this edge
         if (req_valid && !req_stall)
            expected_blends.push_back(predict_blend(req_point_x, req_point_y, req_point_z,
               req_attr_at_a, req_attr_at_b, req_attr_at_c, req_last_element));
         if (csr_write_enable) begin
            case (bai_pkg::csr_index_type'(csr_index))
               bai_pkg::CSR_VERTEX_A:     vert_a = csr_write_data;
               bai_pkg::CSR_VERTEX_B:     vert_b = csr_write_data;
               bai_pkg::CSR_VERTEX_C:     vert_c = csr_write_data;
               bai_pkg::CSR_INSIDE_LIMIT: limit_q = csr_write_data[bai_pkg::LIMIT_WIDTH-1:0];
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            response_count++;
            if (rsp_inside_res) inside_count++;
            if (expected_blends.size() == 0) begin
               report_mismatch("response with none outstanding", 1, 0);
            end else begin
               want = expected_blends.pop_front();
               if (rsp_blended_value !== want.blended)
                  report_mismatch("blended_value", rsp_blended_value, want.blended);
               if (rsp_inside_res !== want.in_tri)
                  report_mismatch("inside_res", rsp_inside_res, want.in_tri);
               if (rsp_last_out !== want.last)
                  report_mismatch("last_out", rsp_last_out, want.last);
            end
         end
      end
      pending_count = expected_blends.size();
   end

endmodule

>>> tb/barycentric_attribute_interpolator_core_tb.sv
`timescale 1ns / 100ps

module barycentric_attribute_interpolator_core_tb;

   localparam int DRAIN_CYCLES = 80;
   localparam int CYCLE_LIMIT  = 400000;

   logic               clock = 0;
   logic               reset = 1;
   logic               csr_write_enable = 0;
   logic [1:0]         csr_index = 0;
   logic [47:0]        csr_write_data = 0;
   logic               req_valid = 0;
   logic               req_stall;
   logic signed [15:0] req_point_x = 0, req_point_y = 0, req_point_z = 0;
   logic signed [15:0] req_attr_at_a = 0, req_attr_at_b = 0, req_attr_at_c = 0;
   logic               req_last_element = 0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic signed [15:0] rsp_blended_value;
   logic               rsp_inside_res;
   logic               rsp_last_out;

   int error_count, pending_count, response_count, inside_count;
   int send_idle_pct = 0, recv_idle_pct = 0;
   int hold_off_cycles = 0;
   int cycle_count = 0;
   int sent_count = 0;

   barycentric_attribute_interpolator_core dut (.*);

   barycentric_attribute_interpolator_checker checker_i (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILURE");
         $finish;
      end
   end

   // receiver stall: random, or a long forced hold-off
   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   function automatic logic [15:0] pack_coord(int unsigned sel);
      case (sel % 6)
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h0000;
         default: return 16'($urandom_range(1600) - 800);
      endcase
   endfunction

   task automatic write_register(bai_pkg::csr_index_type idx, logic [47:0] data);
      @(posedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   task automatic load_triangle(logic [47:0] a, logic [47:0] b, logic [47:0] c,
                                logic [17:0] lim);
      write_register(bai_pkg::CSR_VERTEX_A, a);
      write_register(bai_pkg::CSR_VERTEX_B, b);
      write_register(bai_pkg::CSR_VERTEX_C, c);
      write_register(bai_pkg::CSR_INSIDE_LIMIT, {30'd0, lim});
   endtask

   // offers one transaction and waits until it is taken
   task automatic send_point(logic [15:0] px, py, pz, aa, ab, ac, logic lst);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_point_x <= px; req_point_y <= py; req_point_z <= pz;
      req_attr_at_a <= aa; req_attr_at_b <= ab; req_attr_at_c <= ac;
      req_last_element <= lst;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   task automatic go_idle();
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // mostly points near the triangle, some anywhere
   task automatic send_random_point();
      logic [15:0] px, py, pz;
      if ($urandom_range(9) < 8) begin
         px = 16'($urandom_range(2000) - 1000);
         py = 16'($urandom_range(2000) - 1000);
         pz = 16'($urandom_range(400) - 200);
      end else begin
         px = 16'($urandom); py = 16'($urandom); pz = 16'($urandom);
      end
      send_point(px, py, pz, 16'($urandom), 16'($urandom), 16'($urandom),
                 1'($urandom));
   endtask

   function automatic logic [47:0] random_vertex();
      return {pack_coord($urandom), pack_coord($urandom), pack_coord($urandom)};
   endfunction

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // default registers: degenerate triangle, all weights saturated
      send_point(16'h7fff, 16'h8000, 16'h0000, 16'h7fff, 16'h7fff, 16'h7fff, 1);
      send_point(16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 0);
      go_idle();

      // flat triangle in z=0, unit-ish size
      load_triangle({16'd0, 16'd0, 16'd0}, {16'd0, 16'd0, 16'd160},
                    {16'd0, 16'd160, 16'd0}, bai_pkg::LIMIT_RESET);
      send_point(16'd0, 16'd0, 16'd0, 16'h0100, 16'h0200, 16'h0300, 0);
      send_point(16'd40, 16'd40, 16'd0, 16'h7fff, 16'h7fff, 16'h7fff, 1);
      send_point(16'd160, 16'd0, 16'd0, 16'h8000, 16'h0000, 16'h7fff, 0);
      send_point(16'd200, 16'd200, 16'd0, 16'h7fff, 16'h7fff, 16'h7fff, 1);
      send_point(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 0);
      send_point(16'h8000, 16'h8000, 16'h8000, 16'hffff, 16'h0001, 16'h5555, 1);
      send_point(16'd80, 16'd80, 16'd0, 16'haaaa, 16'h5555, 16'h0000, 0);
      go_idle();

      // extreme vertices, zero and full limit
      load_triangle({16'h7fff, 16'h8000, 16'h7fff}, {16'h8000, 16'h7fff, 16'h8000},
                    {16'h0000, 16'h7fff, 16'h8000}, 18'd0);
      send_point(16'd0, 16'd0, 16'd0, 16'h1234, 16'hedcb, 16'h7fff, 1);
      send_point(16'h7fff, 16'h8000, 16'h7fff, 16'h0100, 16'h0100, 16'h0100, 0);
      go_idle();
      write_register(bai_pkg::CSR_INSIDE_LIMIT, 48'h3ffff);
      send_point(16'd0, 16'd0, 16'd0, 16'h1234, 16'hedcb, 16'h7fff, 1);
      send_point(16'h0010, 16'hfff0, 16'h0020, 16'h0100, 16'h0100, 16'h0100, 0);
      go_idle();

      // random phases with differing triangles and idling patterns
      for (int phase = 0; phase < 9; phase++) begin
         case (phase % 3)
            0: begin send_idle_pct = 19; recv_idle_pct = 76; end
            1: begin send_idle_pct = 76; recv_idle_pct = 19; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         if (phase % 4 == 3)
            load_triangle(random_vertex(), random_vertex(), random_vertex(),
                          18'($urandom));
         else
            load_triangle({16'($urandom_range(200) - 100), 16'($urandom_range(1000) - 500),
                           16'($urandom_range(1000) - 500)},
                          {16'($urandom_range(200) - 100), 16'($urandom_range(1000) - 500),
                           16'($urandom_range(1000) - 500)},
                          {16'($urandom_range(200) - 100), 16'($urandom_range(1000) - 500),
                           16'($urandom_range(1000) - 500)},
                          18'($urandom_range(65536 * 3, 65536)));
         // long receiver hold-off so the pipeline backs up into the request side
         if (phase == 2) hold_off_cycles = 300;
         for (int i = 0; i < 75; i++) send_random_point();
         go_idle();
      end

      $display("sent %0d transactions, %0d responses checked, %0d flagged inside",
               sent_count, response_count, inside_count);
      $display("covered degenerate, far, extreme and random triangles under back-pressure");
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
